// File: sv/aprm_pkg.sv
// ----------------------------------------------------------------------------
// aprm_pkg
// shared constants, register codes and width helpers of the level meter
// ----------------------------------------------------------------------------
package aprm_pkg;

  localparam int DefSampleBits = 24;
  localparam int DefMaxBlock   = 4096;
  localparam int QueueDepth    = 2;
  localparam int Log2W         = 22;

  localparam logic [15:0]        AttackRst  = 16'd26214;
  localparam logic [15:0]        ReleaseRst = 16'd5243;
  localparam logic signed [15:0] FloorRst   = -16'sd23040;
  localparam logic [18:0]        DbPerLog2  = 19'd394566;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_FLOOR   = 2'd2
  } cfg_reg_e;

  function automatic int sum_width(int sb, int mb);
    int w;
    w = 2 * sb + $clog2(mb + 1);
    return (w > 64) ? 64 : w;
  endfunction

  function automatic int cnt_width(int mb);
    return $clog2(mb + 1);
  endfunction

endpackage

// File: sv/aprm_queue.sv
// ----------------------------------------------------------------------------
// aprm_queue
// short fifo holding finished block totals between front and back
// ----------------------------------------------------------------------------
module aprm_queue import aprm_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/aprm_front.sv
// ----------------------------------------------------------------------------
// aprm_front
// takes samples, keeps block peak, sum of squares and count, queues totals
// ----------------------------------------------------------------------------
module aprm_front import aprm_pkg::*; #(
  parameter int SAMPLE_BITS = DefSampleBits,
  parameter int MAX_BLOCK   = DefMaxBlock,
  localparam int SumW = sum_width(SAMPLE_BITS, MAX_BLOCK),
  localparam int CntW = cnt_width(MAX_BLOCK),
  localparam int JobW = SAMPLE_BITS + SumW + CntW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  input  logic                   full_i,
  output logic                   push_o,
  output logic [JobW-1:0]        job_o
);

  localparam int SqW = 2 * SAMPLE_BITS;

  logic                   s1_q, s2_q;
  logic [SAMPLE_BITS-1:0] mag1_q, mag2_q;
  logic                   end1_q, end2_q;
  logic [SqW-1:0]         sq_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [SumW-1:0]        sum_q;
  logic [CntW-1:0]        cnt_q;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] mag_d;
  logic [SumW:0]          sum_ext;
  logic [SumW-1:0]        sum_n;
  logic [SAMPLE_BITS-1:0] peak_n;
  logic [CntW-1:0]        cnt_n;
  logic                   end_n;

  // one sample in flight at a time, so a queue slot is free when the block ends
  assign in_ready_o = !(s1_q || s2_q) && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // most negative sample wraps to full scale as unsigned
  assign mag_d = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;

  always_comb begin
    sum_ext = {1'b0, sum_q} + (SumW + 1)'(sq_q);
    sum_n   = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
    peak_n  = (mag2_q > peak_q) ? mag2_q : peak_q;
    cnt_n   = cnt_q + 1'b1;
    end_n   = end2_q || (cnt_n >= CntW'(MAX_BLOCK));
  end

  assign push_o = s2_q && end_n;
  assign job_o  = {cnt_n, sum_n, peak_n};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag1_q <= mag_d;
      end1_q <= last_i;
    end
    if (s1_q) begin
      sq_q   <= mag1_q * mag1_q;
      mag2_q <= mag1_q;
      end2_q <= end1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      peak_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      s1_q <= accept;
      s2_q <= s1_q;
      if (s2_q) begin
        if (end_n) begin
          peak_q <= '0;
          sum_q  <= '0;
          cnt_q  <= '0;
        end else begin
          peak_q <= peak_n;
          sum_q  <= sum_n;
          cnt_q  <= cnt_n;
        end
      end
    end
  end

endmodule

// File: sv/aprm_log2.sv
// ----------------------------------------------------------------------------
// aprm_log2
// iterative log2 in q16: bit-serial normalise, then 16 square-and-compare
// ----------------------------------------------------------------------------
module aprm_log2 import aprm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      x_i,
  output logic             done_o,
  output logic [Log2W-1:0] res_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_MUL,
    L_EVAL
  } lstate_e;

  lstate_e     state_q;
  logic [63:0] x_q;
  logic [5:0]  e_q;
  logic [31:0] m_q;
  logic [63:0] p_q;
  logic [15:0] frac_q;
  logic [3:0]  step_q;
  logic        done_q;
  logic [32:0] q;

  assign q      = p_q[63:31];
  assign done_o = done_q;
  assign res_o  = {e_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      x_q     <= '0;
      e_q     <= '0;
      m_q     <= '0;
      p_q     <= '0;
      frac_q  <= '0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            e_q     <= 6'd63;
            frac_q  <= '0;
            step_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (e_q != '0 && !x_q[63]) begin
            x_q <= x_q << 1;
            e_q <= e_q - 1'b1;
          end else begin
            m_q     <= x_q[63:32];
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          p_q     <= m_q * m_q;
          state_q <= L_EVAL;
        end
        L_EVAL: begin
          frac_q <= {frac_q[14:0], q[32]};
          m_q    <= q[32] ? q[32:1] : q[31:0];
          step_q <= step_q + 1'b1;
          if (step_q == 4'd15) begin
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end else begin
            state_q <= L_MUL;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

endmodule

// File: sv/aprm_back.sv
// ----------------------------------------------------------------------------
// aprm_back
// per-block sequencer: logs, dB conversion, floor, ballistics, result register
// ----------------------------------------------------------------------------
module aprm_back import aprm_pkg::*; #(
  parameter int SAMPLE_BITS = DefSampleBits,
  parameter int MAX_BLOCK   = DefMaxBlock,
  localparam int SumW = sum_width(SAMPLE_BITS, MAX_BLOCK),
  localparam int CntW = cnt_width(MAX_BLOCK),
  localparam int JobW = SAMPLE_BITS + SumW + CntW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  logic [JobW-1:0]    job_i,
  output logic               pop_o,
  input  logic [15:0]        attack_i,
  input  logic [15:0]        release_i,
  input  logic signed [15:0] floor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        peak_o,
  output logic [15:0]        rms_o
);

  localparam logic [24:0] PeakBase = 25'((SAMPLE_BITS - 1) * 65536);
  localparam logic [24:0] RmsBase  = 25'(2 * (SAMPLE_BITS - 1) * 65536);

  typedef enum logic [3:0] {
    B_IDLE, B_LP, B_LPW, B_LS, B_LSW, B_LC, B_LCW, B_ATT,
    B_DBP, B_DBR, B_TGT, B_SMP, B_SMP2, B_SMR, B_SMR2, B_OUT
  } bstate_e;

  bstate_e                state_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [SumW-1:0]        sum_q;
  logic [CntW-1:0]        cnt_q;
  logic [Log2W-1:0]       lp_q, ls_q, lc_q;
  logic [23:0]            attp_q, attr_q;
  logic [42:0]            mulp_q, mulr_q;
  logic signed [15:0]     tp_q, tr_q, sp_q, sr_q;
  logic signed [33:0]     smul_q;
  logic                   out_valid_q;
  logic [15:0]            peak_out_q, rms_out_q;

  logic             log_start, log_done;
  logic [63:0]      log_x;
  logic [Log2W-1:0] log_res;

  logic [24:0]        ap, ar;
  logic [42:0]        dbmul;
  logic [43:0]        rp, rr;
  logic [19:0]        mp;
  logic [18:0]        mr;
  logic [16:0]        mps, mrs;
  logic signed [16:0] tpv, trv, fv, tpc, trc;
  logic signed [15:0] cur, tgt;
  logic signed [16:0] diff, cs;
  logic signed [33:0] bsum;
  logic signed [17:0] stp, curx, nv;
  logic               load;

  aprm_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  assign pop_o       = (state_q == B_IDLE) && job_valid_i;
  assign log_start   = (state_q == B_LP) || (state_q == B_LS) || (state_q == B_LC);
  assign load        = (state_q == B_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign peak_o      = peak_out_q;
  assign rms_o       = rms_out_q;

  always_comb begin
    case (state_q)
      B_LP:    log_x = 64'(peak_q);
      B_LS:    log_x = 64'(sum_q);
      default: log_x = 64'(cnt_q);
    endcase
  end

  // attenuation in log2 units, clamped at zero
  always_comb begin
    ap = PeakBase - 25'(lp_q);
    ar = RmsBase - 25'(ls_q) + 25'(lc_q);
  end

  assign dbmul = ((state_q == B_DBP) ? attp_q : attr_q) * DbPerLog2;

  // round, saturate and negate, then clamp at the floor; silence maps to the bottom code
  always_comb begin
    rp  = {1'b0, mulp_q} + (44'd1 << 23);
    rr  = {1'b0, mulr_q} + (44'd1 << 24);
    mp  = rp[43:24];
    mr  = rr[43:25];
    mps = (mp > 20'd32768) ? 17'd32768 : mp[16:0];
    mrs = (mr > 19'd32768) ? 17'd32768 : mr[16:0];
    tpv = (peak_q == '0) ? -17'sd32768 : -$signed(mps);
    trv = (sum_q == '0) ? -17'sd32768 : -$signed(mrs);
    fv  = (!floor_i[15] && floor_i != '0) ? 17'sd0 : 17'(floor_i);
    tpc = (tpv < fv) ? fv : tpv;
    trc = (trv < fv) ? fv : trv;
  end

  // ballistics: attack coefficient when rising, release coefficient otherwise
  always_comb begin
    cur  = (state_q == B_SMP || state_q == B_SMP2) ? sp_q : sr_q;
    tgt  = (state_q == B_SMP || state_q == B_SMP2) ? tp_q : tr_q;
    diff = 17'(tgt) - 17'(cur);
    cs   = $signed({1'b0, (tgt > cur) ? attack_i : release_i});
    bsum = smul_q + 34'sd32768;
    stp  = bsum[33:16];
    curx = 18'(cur);
    nv   = curx + stp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      sp_q        <= FloorRst;
      sr_q        <= FloorRst;
      peak_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      lp_q        <= '0;
      ls_q        <= '0;
      lc_q        <= '0;
      attp_q      <= '0;
      attr_q      <= '0;
      mulp_q      <= '0;
      mulr_q      <= '0;
      tp_q        <= '0;
      tr_q        <= '0;
      smul_q      <= '0;
      peak_out_q  <= '0;
      rms_out_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        peak_out_q  <= sp_q;
        rms_out_q   <= sr_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            {cnt_q, sum_q, peak_q} <= job_i;
            state_q <= B_LP;
          end
        end
        B_LP:  state_q <= B_LPW;
        B_LPW: begin
          if (log_done) begin
            lp_q    <= log_res;
            state_q <= B_LS;
          end
        end
        B_LS:  state_q <= B_LSW;
        B_LSW: begin
          if (log_done) begin
            ls_q    <= log_res;
            state_q <= B_LC;
          end
        end
        B_LC:  state_q <= B_LCW;
        B_LCW: begin
          if (log_done) begin
            lc_q    <= log_res;
            state_q <= B_ATT;
          end
        end
        B_ATT: begin
          attp_q  <= ap[24] ? '0 : ap[23:0];
          attr_q  <= ar[24] ? '0 : ar[23:0];
          state_q <= B_DBP;
        end
        B_DBP: begin
          mulp_q  <= dbmul;
          state_q <= B_DBR;
        end
        B_DBR: begin
          mulr_q  <= dbmul;
          state_q <= B_TGT;
        end
        B_TGT: begin
          tp_q    <= tpc[15:0];
          tr_q    <= trc[15:0];
          state_q <= B_SMP;
        end
        B_SMP: begin
          smul_q  <= diff * cs;
          state_q <= B_SMP2;
        end
        B_SMP2: begin
          sp_q    <= nv[15:0];
          state_q <= B_SMR;
        end
        B_SMR: begin
          smul_q  <= diff * cs;
          state_q <= B_SMR2;
        end
        B_SMR2: begin
          sr_q    <= nv[15:0];
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// File: sv/audio_peak_rms_level_meter.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_level_meter
// peak and rms level meter with attack and release ballistics
// ----------------------------------------------------------------------------
// s_axis carries one signed audio sample per transaction in the low bits of
// tdata; tlast marks the last sample of a block. a block also closes on its
// MAX_BLOCK-th sample. one m_axis transaction follows each block: smoothed
// peak and rms levels, q8.8 dB relative to full scale.
// the front holds one sample at a time (magnitude, square, accumulate)
// and hands block totals to a two-entry queue. the back converts one block
// at a time, paced by the serial log2 unit used three times per block.
// configuration goes through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// writes it only while idle, which the block itself does not enforce.
// reset clears the accumulators, restores the default coefficients and floor
// and sets both meters to minus ninety dB. a stalled m_axis holds its result;
// the back then waits, the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module audio_peak_rms_level_meter import aprm_pkg::*; #(
  parameter int SAMPLE_BITS = DefSampleBits,
  parameter int MAX_BLOCK   = DefMaxBlock,
  localparam int InW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int SumW = sum_width(SAMPLE_BITS, MAX_BLOCK),
  localparam int CntW = cnt_width(MAX_BLOCK),
  localparam int JobW = SAMPLE_BITS + SumW + CntW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [InW-1:0] s_axis_tdata,  // sample
  input  logic           s_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [31:0]    m_axis_tdata,  // peak_level_db, rms_level_db
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  logic [15:0]        attack_q, release_q;
  logic signed [15:0] floor_q;

  logic            push, pop, empty, full;
  logic [JobW-1:0] job_w, job_r;
  logic [15:0]     peak_db, rms_db;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= AttackRst;
      release_q <= ReleaseRst;
      floor_q   <= FloorRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTACK:  attack_q  <= cfg_wdata_i;
        REG_RELEASE: release_q <= cfg_wdata_i;
        REG_FLOOR:   floor_q   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  aprm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i     (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_w)
  );

  aprm_queue #(
    .W     (JobW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_w),
    .pop_i   (pop),
    .rdata_o (job_r),
    .empty_o (empty),
    .full_o  (full)
  );

  aprm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (job_r),
    .pop_o       (pop),
    .attack_i    (attack_q),
    .release_i   (release_q),
    .floor_i     (floor_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .peak_o      (peak_db),
    .rms_o       (rms_db)
  );

  assign m_axis_tdata = {rms_db, peak_db};

endmodule

// File: sv/aprm_checker.sv
// ----------------------------------------------------------------------------
// aprm_checker
// port-level checks on the result channel of the level meter
// ----------------------------------------------------------------------------
module aprm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // levels are relative to full scale and never positive
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15] || m_axis_tdata[15:0] == 16'd0))
    else $error("peak level above full scale");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31] || m_axis_tdata[31:16] == 16'd0))
    else $error("rms level above full scale");

endmodule

bind audio_peak_rms_level_meter aprm_checker u_aprm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
